FILE: rtl/point_line_distance_core_assert.svh
// Assertion macros shared by the point-to-line distance RTL
`ifndef POINT_LINE_DISTANCE_CORE_ASSERT_SVH
`define POINT_LINE_DISTANCE_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define PLD_ASSERT(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that one condition implies another in the next cycle
`define PLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pld_pkg.sv
// Package: constants of the point-to-line distance datapath
`timescale 1ns / 1ps
package pld_pkg;
  // Result width of the fixed-point distance
  localparam int OUT_BITS = 25;
  // Scaled cross-product-square bits at or above this position force saturation
  localparam int HUGE_POS = 128;
endpackage

FILE: rtl/pld_if.sv
// Stream interfaces: query beats in, distance beats out
`timescale 1ns / 1ps
interface pld_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] ax;
  logic signed [COORD_WIDTH-1:0] ay;
  logic signed [COORD_WIDTH-1:0] bx;
  logic signed [COORD_WIDTH-1:0] by_coord;
  logic signed [COORD_WIDTH-1:0] cx;
  logic signed [COORD_WIDTH-1:0] cy;

  modport source (output valid, ax, ay, bx, by_coord, cx, cy, input ready);
  modport sink   (input valid, ax, ay, bx, by_coord, cx, cy, output ready);
endinterface

interface pld_out_if;
  logic        valid;
  logic        ready;
  logic [24:0] dist_fixed;
  logic        degenerate;

  modport source (output valid, dist_fixed, degenerate, input ready);
  modport sink   (input valid, dist_fixed, degenerate, output ready);
endinterface

FILE: rtl/point_line_distance_core.sv
// Point-to-line distance: fully pipelined, one query beat per cycle unless stalled.
// Structure: 5 arithmetic stages from input beat to output beat, then
// one restoring square-root/divide stage per result bit, 25 in all.
// Throughput: one beat per cycle; a stalled output freezes the whole pipe.
// Reset: asynchronous, active low; clears only the stage valid bits.
`timescale 1ns / 1ps
module point_line_distance_core #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pld_in_if.sink     in_if,
  pld_out_if.source  out_if
);
  import pld_pkg::*;

  localparam int DW   = COORD_WIDTH + 1;
  localparam int PW   = 2 * DW;
  localparam int HALF = (PW + 1) / 2;
  localparam int HIW  = PW - HALF;
  localparam int RW   = 2 * PW + 2 * FRAC_BITS;
  localparam int CW0  = (RW > 2 * OUT_BITS + PW) ? RW : 2 * OUT_BITS + PW;
  localparam int CWID = CW0 + 2;
  localparam int NST  = OUT_BITS;

  logic en;
  assign en           = !out_if.valid || out_if.ready;
  assign in_if.ready  = en;

  // Stage 1: differences and degenerate test
  logic                 v1_q, dg1_q;
  logic signed [DW-1:0] dx_q, dy_q, ex_q, ey_q;
  logic signed [DW-1:0] dx_d, dy_d, ex_d, ey_d;

  always_comb begin
    dx_d = DW'(in_if.bx) - DW'(in_if.ax);
    dy_d = DW'(in_if.by_coord) - DW'(in_if.ay);
    ex_d = DW'(in_if.cx) - DW'(in_if.ax);
    ey_d = DW'(in_if.cy) - DW'(in_if.ay);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      ex_q  <= ex_d;
      ey_q  <= ey_d;
      dg1_q <= (dx_d == '0) && (dy_d == '0);
    end
  end

  // Stage 2: four products
  logic                 v2_q, dg2_q;
  logic signed [PW-1:0] m1_q, m2_q, mxx_q, myy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q  <= PW'(dx_q) * PW'(ey_q);
      m2_q  <= PW'(dy_q) * PW'(ex_q);
      mxx_q <= PW'(dx_q) * PW'(dx_q);
      myy_q <= PW'(dy_q) * PW'(dy_q);
      dg2_q <= dg1_q;
    end
  end

  // Stage 3: cross product magnitude and squared length
  logic                   v3_q, dg3_q;
  logic [PW-1:0]          ac_q, len_q;
  logic signed [PW:0]     cr_d;

  assign cr_d = (PW + 1)'(m1_q) - (PW + 1)'(m2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ac_q  <= cr_d[PW] ? PW'(-cr_d) : PW'(cr_d);
      len_q <= PW'(mxx_q) + PW'(myy_q);
      dg3_q <= dg2_q;
    end
  end

  // Stage 4: partial products of the cross product square
  logic                  v4_q, dg4_q;
  logic [PW-1:0]         len4_q;
  logic [2*HALF-1:0]     ll_q;
  logic [HIW+HALF-1:0]   hl_q;
  logic [2*HIW-1:0]      hh_q;
  logic [HALF-1:0]       ac_lo;
  logic [HIW-1:0]        ac_hi;

  assign ac_lo = ac_q[HALF-1:0];
  assign ac_hi = ac_q[PW-1:HALF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ll_q   <= (2 * HALF)'(ac_lo) * (2 * HALF)'(ac_lo);
      hl_q   <= (HIW + HALF)'(ac_hi) * (HIW + HALF)'(ac_lo);
      hh_q   <= (2 * HIW)'(ac_hi) * (2 * HIW)'(ac_hi);
      len4_q <= len_q;
      dg4_q  <= dg3_q;
    end
  end

  // Stage 5: assemble the scaled right-hand side, seed the root stages
  logic [RW-1:0]   rhs_d;
  logic            huge_d;

  assign rhs_d = ((RW'(hh_q) << (2 * HALF)) + (RW'(hl_q) << (HALF + 1)) + RW'(ll_q))
                 << (2 * FRAC_BITS);

  generate
    if (RW > HUGE_POS) begin : g_huge
      assign huge_d = |rhs_d[RW-1:HUGE_POS];
    end else begin : g_nohuge
      assign huge_d = 1'b0;
    end
  endgenerate

  logic                v_q    [NST+1];
  logic                dg_q   [NST+1];
  logic                hg_q   [NST+1];
  logic [CWID-1:0]     r_q    [NST+1];
  logic [PW-1:0]       l_q    [NST+1];
  logic [CWID-1:0]     p_q    [NST+1];
  logic [CWID-1:0]     ql_q   [NST+1];
  logic [OUT_BITS-1:0] q_q    [NST+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q[0]  <= CWID'(rhs_d);
      hg_q[0] <= huge_d;
      l_q[0]  <= len4_q;
      dg_q[0] <= dg4_q;
      p_q[0]  <= '0;
      ql_q[0] <= '0;
      q_q[0]  <= '0;
    end
  end

  // Root stages: try one result bit each, most significant first
  for (genvar i = 0; i < NST; i++) begin : g_root
    localparam int B = OUT_BITS - 1 - i;
    logic [CWID-1:0] lx, cand;
    logic            take;

    assign lx   = CWID'(l_q[i]);
    assign cand = p_q[i] + (ql_q[i] << (B + 1)) + (lx << (2 * B));
    assign take = hg_q[i] || (cand <= r_q[i]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        r_q[i+1]  <= r_q[i];
        hg_q[i+1] <= hg_q[i];
        l_q[i+1]  <= l_q[i];
        dg_q[i+1] <= dg_q[i];
        p_q[i+1]  <= take ? cand : p_q[i];
        ql_q[i+1] <= take ? ql_q[i] + (lx << B) : ql_q[i];
        q_q[i+1]  <= take ? (q_q[i] | (OUT_BITS'(1) << B)) : q_q[i];
      end
    end
  end

  // Drive the output beat; a degenerate line reads as zero distance
  assign out_if.valid      = v_q[NST];
  assign out_if.degenerate = dg_q[NST];
  assign out_if.dist_fixed = dg_q[NST] ? '0 : q_q[NST];

`include "point_line_distance_core_assert.svh"

  `PLD_ASSERT(a_degen_zero, clk_i, rst_ni, !(out_if.valid && out_if.degenerate) || (out_if.dist_fixed == '0), "degenerate beat with nonzero distance")
  `PLD_ASSERT(a_ready_free, clk_i, rst_ni, out_if.valid || in_if.ready, "input stalled while output is empty")
  `PLD_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_if.valid && !out_if.ready, out_if.valid && $stable(q_q[NST]) && $stable(v_q[0]), "pipeline moved during an output stall")
endmodule
